// ----- sv/temp_press_hum_compensation_assert.svh -----
`ifndef TEMP_PRESS_HUM_COMPENSATION_ASSERT_SVH
`define TEMP_PRESS_HUM_COMPENSATION_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TPH_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tph check failed");

// next-cycle implication, checked outside reset
`define TPH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tph check failed");

`endif

// ----- sv/tph_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tph_pkg;

    localparam int IN_W  = 56;
    localparam int OUT_W = 88;

    localparam logic [2:0] REG_TEMP_CAL    = 3'd0;
    localparam logic [2:0] REG_PRESS_CAL_A = 3'd1;
    localparam logic [2:0] REG_PRESS_CAL_B = 3'd2;
    localparam logic [2:0] REG_PRESS_CAL_C = 3'd3;
    localparam logic [2:0] REG_HUM_CAL_A   = 3'd4;
    localparam logic [2:0] REG_HUM_CAL_B   = 3'd5;

    localparam logic [19:0] RAW_PT_SENTINEL = 20'h80000;
    localparam logic [15:0] RAW_H_SENTINEL  = 16'h8000;
    localparam logic [31:0] HUM_LIMIT       = 32'd419430400;

    typedef struct packed {
        logic        sentinel;
        logic [15:0] adc_h;
        logic [19:0] adc_t;
        logic [19:0] adc_p;
    } tph_item_t;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
        logic [7:0]  h1;
        logic [15:0] h2;
        logic [7:0]  h3;
        logic [15:0] h4;
        logic [15:0] h5;
        logic [7:0]  h6;
    } tph_cal_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_T0, ST_T1, ST_T2,
        ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6,
        ST_DIV,
        ST_P7, ST_P8, ST_P9,
        ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6, ST_H7,
        ST_DONE
    } tph_state_t;

    function automatic logic [63:0] sx16_64(input logic [15:0] x);
        return {{48{x[15]}}, x};
    endfunction

    function automatic logic [31:0] sx16_32(input logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

    function automatic logic [31:0] sx8_32(input logic [7:0] x);
        return {{24{x[7]}}, x};
    endfunction

endpackage

`default_nettype wire

// ----- sv/tph_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tph_mul
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        w64,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic             done,
    output logic [63:0]      p
);

    logic [63:0] a_reg, b_reg, acc_reg, acc_next;
    logic        w64_reg, busy_reg, done_reg, last;
    logic [1:0]  step_reg;
    logic [31:0] x, y;
    logic [63:0] prod;

    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                x = a_reg[31:0];
                y = b_reg[31:0];
            end
            2'd1:
            begin
                x = a_reg[63:32];
                y = b_reg[31:0];
            end
            default:
            begin
                x = a_reg[31:0];
                y = b_reg[63:32];
            end
        endcase
        prod = x * y;
        if (step_reg == 2'd0)
        begin
            acc_next = prod;
        end
        else
        begin
            acc_next = acc_reg + {prod[31:0], 32'd0};
        end
        last = w64_reg ? (step_reg == 2'd2) : (step_reg == 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                busy_reg <= !last;
                step_reg <= step_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            w64_reg <= w64;
        end
        if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

`default_nettype wire

// ----- sv/tph_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tph_div
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] n,
    input  wire logic [63:0] d,
    output logic             done,
    output logic [63:0]      q
);

    logic [63:0] quo_reg, den_reg;
    logic [64:0] rem_reg, shifted;
    logic        neg_reg, busy_reg, done_reg, ge;
    logic [5:0]  cnt_reg;

    always_comb
    begin
        shifted = {rem_reg[63:0], quo_reg[63]};
        ge      = shifted >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 6'd63);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                busy_reg <= cnt_reg != 6'd63;
                cnt_reg  <= cnt_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= n[63] ^ d[63];
            quo_reg <= n[63] ? (64'd0 - n) : n;
            den_reg <= d[63] ? (64'd0 - d) : d;
            rem_reg <= 65'd0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (shifted - {1'b0, den_reg}) : shifted;
            quo_reg <= {quo_reg[62:0], ge};
        end
    end

    assign done = done_reg;
    assign q    = neg_reg ? (64'd0 - quo_reg) : quo_reg;

endmodule

`default_nettype wire

// ----- sv/tph_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tph_fifo
    import tph_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire tph_item_t wr_item,
    input  wire logic      pop,
    output logic           full,
    output logic           not_empty,
    output tph_item_t      rd_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    tph_item_t         mem [DEPTH];
    logic [AW-1:0]     wr_reg, rd_reg;
    logic [CW-1:0]     cnt_reg;

    assign full      = cnt_reg == CW'(DEPTH);
    assign not_empty = cnt_reg != '0;
    assign rd_item   = mem[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == LAST) ? '0 : wr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == LAST) ? '0 : rd_reg + AW'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

// ----- sv/tph_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tph_front
    import tph_pkg::*;
(
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [IN_W-1:0] s_tdata,
    input  wire logic            q_full,
    output logic                 q_push,
    output tph_item_t            q_item
);

    always_comb
    begin
        s_tready       = !q_full;
        q_push         = s_tvalid && !q_full;
        q_item.adc_p   = s_tdata[19:0];
        q_item.adc_t   = s_tdata[39:20];
        q_item.adc_h   = s_tdata[55:40];
        q_item.sentinel = (s_tdata[19:0] == RAW_PT_SENTINEL)
                       || (s_tdata[39:20] == RAW_PT_SENTINEL)
                       || (s_tdata[55:40] == RAW_H_SENTINEL);
    end

endmodule

`default_nettype wire

// ----- sv/tph_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tph_back
    import tph_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    input  wire tph_item_t        q_item,
    output logic                  q_pop,
    input  wire tph_cal_t         cal,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata
);

    tph_state_t state_reg, state_next, after;
    logic       go_reg, go_next, out_valid_reg, out_valid_next, use_mul, load_out;
    logic       mul_start, mul_w64, mul_done, div_start, div_done;
    logic [63:0] mul_a, mul_b, mul_p, div_q;
    tph_item_t  item_reg;

    logic [31:0] ta_reg, tb_reg, tf_reg, c_reg, d1_reg, d2_reg, d_reg, e_reg;
    logic [31:0] v2_reg, g0_reg, temp_reg, press_reg;
    logic [16:0] hum_reg;
    logic        ok_reg;
    logic [63:0] xx_reg, x2_reg, y_reg, num_reg, p_reg, w_reg, px1_reg;
    logic [OUT_W-1:0] out_data_reg;

    logic [63:0] x1, q13, z_val, psum;
    logic [31:0] hv, fsq, tf5, temp_val, v3, hclamp, lo32;

    assign lo32     = mul_p[31:0];
    assign x1       = {{32{tf_reg[31]}}, tf_reg} - 64'd128000;
    assign hv       = tf_reg - 32'd76800;
    assign q13      = 64'($signed(p_reg) >>> 13);
    assign fsq      = 32'($signed(v2_reg) >>> 15);
    assign z_val    = 64'($signed(mul_p) >>> 33);
    assign tf5      = {tf_reg[29:0], 2'b00} + tf_reg + 32'd128;
    assign temp_val = 32'($signed(tf5) >>> 8);
    assign psum     = p_reg + px1_reg + 64'($signed(mul_p) >>> 19);
    assign v3       = v2_reg - 32'($signed(lo32) >>> 4);
    assign hclamp   = v3[31] ? 32'd0 : ((v3 > HUM_LIMIT) ? HUM_LIMIT : v3);

    tph_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .w64   (mul_w64),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    tph_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n     (num_reg),
        .d     (x2_reg),
        .done  (div_done),
        .q     (div_q)
    );

    always_comb
    begin
        state_next     = state_reg;
        go_next        = go_reg;
        out_valid_next = out_valid_reg && !m_tready;
        load_out       = 1'b0;
        q_pop          = 1'b0;
        mul_start      = 1'b0;
        div_start      = 1'b0;
        mul_w64        = 1'b0;
        mul_a          = 64'd0;
        mul_b          = 64'd0;
        use_mul        = 1'b1;
        after          = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                use_mul = 1'b0;
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = q_item.sentinel ? ST_DONE : ST_T0;
                end
            end
            ST_T0:
            begin
                mul_a = {32'd0, {12'd0, item_reg.adc_t[19:3]} - {15'd0, cal.t1, 1'b0}};
                mul_b = {32'd0, sx16_32(cal.t2)};
                after = ST_T1;
            end
            ST_T1:
            begin
                mul_a = {32'd0, {16'd0, item_reg.adc_t[19:4]} - {16'd0, cal.t1}};
                mul_b = mul_a;
                after = ST_T2;
            end
            ST_T2:
            begin
                mul_a = {32'd0, tb_reg};
                mul_b = {32'd0, sx16_32(cal.t3)};
                after = ST_P0;
            end
            ST_P0:
            begin
                mul_w64 = 1'b1;
                mul_a   = x1;
                mul_b   = x1;
                after   = ST_P1;
            end
            ST_P1:
            begin
                mul_w64 = 1'b1;
                mul_a   = xx_reg;
                mul_b   = sx16_64(cal.p6);
                after   = ST_P2;
            end
            ST_P2:
            begin
                mul_w64 = 1'b1;
                mul_a   = x1;
                mul_b   = sx16_64(cal.p5);
                after   = ST_P3;
            end
            ST_P3:
            begin
                mul_w64 = 1'b1;
                mul_a   = xx_reg;
                mul_b   = sx16_64(cal.p3);
                after   = ST_P4;
            end
            ST_P4:
            begin
                mul_w64 = 1'b1;
                mul_a   = x1;
                mul_b   = sx16_64(cal.p2);
                after   = ST_P5;
            end
            ST_P5:
            begin
                mul_w64 = 1'b1;
                mul_a   = (64'd1 << 47) + y_reg;
                mul_b   = {48'd0, cal.p1};
                after   = (z_val == 64'd0) ? ST_H0 : ST_P6;
            end
            ST_P6:
            begin
                mul_w64 = 1'b1;
                mul_a   = ((64'd1048576 - {44'd0, item_reg.adc_p}) << 31) - num_reg;
                mul_b   = 64'd3125;
                after   = ST_DIV;
            end
            ST_DIV:
            begin
                use_mul = 1'b0;
                if (!go_reg)
                begin
                    div_start = 1'b1;
                    go_next   = 1'b1;
                end
                else if (div_done)
                begin
                    go_next    = 1'b0;
                    state_next = ST_P7;
                end
            end
            ST_P7:
            begin
                mul_w64 = 1'b1;
                mul_a   = sx16_64(cal.p9);
                mul_b   = q13;
                after   = ST_P8;
            end
            ST_P8:
            begin
                mul_w64 = 1'b1;
                mul_a   = w_reg;
                mul_b   = q13;
                after   = ST_P9;
            end
            ST_P9:
            begin
                mul_w64 = 1'b1;
                mul_a   = sx16_64(cal.p8);
                mul_b   = p_reg;
                after   = ST_H0;
            end
            ST_H0:
            begin
                mul_a = {32'd0, sx16_32(cal.h5)};
                mul_b = {32'd0, hv};
                after = ST_H1;
            end
            ST_H1:
            begin
                mul_a = {32'd0, hv};
                mul_b = {32'd0, sx8_32(cal.h6)};
                after = ST_H2;
            end
            ST_H2:
            begin
                mul_a = {32'd0, hv};
                mul_b = {56'd0, cal.h3};
                after = ST_H3;
            end
            ST_H3:
            begin
                mul_a = {32'd0, d1_reg};
                mul_b = {32'd0, d2_reg};
                after = ST_H4;
            end
            ST_H4:
            begin
                mul_a = {32'd0, d_reg};
                mul_b = {32'd0, sx16_32(cal.h2)};
                after = ST_H5;
            end
            ST_H5:
            begin
                mul_a = {32'd0, c_reg};
                mul_b = {32'd0, e_reg};
                after = ST_H6;
            end
            ST_H6:
            begin
                mul_a = {32'd0, fsq};
                mul_b = {32'd0, fsq};
                after = ST_H7;
            end
            ST_H7:
            begin
                mul_a = {32'd0, g0_reg};
                mul_b = {56'd0, cal.h1};
                after = ST_DONE;
            end
            ST_DONE:
            begin
                use_mul = 1'b0;
                if (!out_valid_reg || m_tready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                use_mul    = 1'b0;
                state_next = ST_IDLE;
            end
        endcase
        if (use_mul)
        begin
            if (!go_reg)
            begin
                mul_start = 1'b1;
                go_next   = 1'b1;
            end
            else if (mul_done)
            begin
                go_next    = 1'b0;
                state_next = after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            go_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            go_reg        <= go_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
            ok_reg   <= !q_item.sentinel;
            if (q_item.sentinel)
            begin
                temp_reg  <= 32'd0;
                press_reg <= 32'd0;
                hum_reg   <= 17'd0;
            end
        end
        if (div_done)
        begin
            p_reg <= div_q;
        end
        if (load_out)
        begin
            out_data_reg <= {6'd0, ok_reg, hum_reg, press_reg, temp_reg};
        end
        if (mul_done)
        begin
            case (state_reg)
                ST_T0: ta_reg <= 32'($signed(lo32) >>> 11);
                ST_T1: tb_reg <= 32'($signed(lo32) >>> 12);
                ST_T2: tf_reg <= ta_reg + 32'($signed(lo32) >>> 14);
                ST_P0:
                begin
                    xx_reg   <= mul_p;
                    temp_reg <= temp_val;
                end
                ST_P1: x2_reg <= mul_p;
                ST_P2: x2_reg <= x2_reg + (mul_p << 17) + (sx16_64(cal.p4) << 35);
                ST_P3: y_reg  <= 64'($signed(mul_p) >>> 8);
                ST_P4: y_reg  <= y_reg + (mul_p << 12);
                ST_P5:
                begin
                    num_reg <= x2_reg;
                    x2_reg  <= z_val;
                    if (z_val == 64'd0)
                    begin
                        press_reg <= 32'd0;
                    end
                end
                ST_P6: num_reg <= mul_p;
                ST_P7: w_reg   <= mul_p;
                ST_P8: px1_reg <= 64'($signed(mul_p) >>> 25);
                ST_P9:
                begin
                    press_reg <= 32'(64'($signed(psum) >>> 8) + (sx16_64(cal.p7) << 4));
                end
                ST_H0:
                begin
                    c_reg <= 32'($signed({2'd0, item_reg.adc_h, 14'd0}
                                 - {cal.h4[11:0], 20'd0} - lo32 + 32'd16384) >>> 15);
                end
                ST_H1: d1_reg <= 32'($signed(lo32) >>> 10);
                ST_H2: d2_reg <= 32'($signed(lo32) >>> 11) + 32'd32768;
                ST_H3: d_reg  <= 32'($signed(lo32) >>> 10) + 32'd2097152;
                ST_H4: e_reg  <= 32'($signed(lo32 + 32'd8192) >>> 14);
                ST_H5: v2_reg <= lo32;
                ST_H6: g0_reg <= 32'($signed(lo32) >>> 7);
                ST_H7: hum_reg <= hclamp[28:12];
                default:
                begin
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ----- sv/temp_press_hum_compensation.sv -----
// The back end computes a normal item with one shared 32x32 multiplier, which builds
// 64-bit products from 32-bit partial products, and a 64-step radix-2 divider; a zero
// pressure divisor skips the divide, and an item with a sentinel raw value skips all
// arithmetic. The back-end multiply/divide sequencer takes one item at a time; later
// items wait in the input queue, which back-pressures s_tready when full.
// Reset: rst_n is asynchronous, active low; clears the queue, sequencer, output valid
// and all calibration registers to zero.
`timescale 1ns / 1ps
`default_nettype none

module temp_press_hum_compensation
    import tph_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // raw_pressure[19:0], raw_temperature[39:20], raw_humidity[55:40]
    input  wire logic [IN_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // temperature_centi[31:0], pressure_q24_8[63:32], humidity_q7_10[80:64],
    // valid_res[81], zero[87:82]
    output logic [OUT_W-1:0]      m_tdata,
    input  wire logic             cfg_we,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [63:0]      cfg_wdata
);

    logic [47:0] temp_cal_reg;
    logic [63:0] press_cal_a_reg, press_cal_b_reg;
    logic [15:0] press_cal_c_reg;
    logic [39:0] hum_cal_a_reg;
    logic [31:0] hum_cal_b_reg;
    tph_cal_t    cal;
    tph_item_t   push_item, pop_item;
    logic        q_full, q_push, q_pop, q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cal_reg    <= '0;
            press_cal_a_reg <= '0;
            press_cal_b_reg <= '0;
            press_cal_c_reg <= '0;
            hum_cal_a_reg   <= '0;
            hum_cal_b_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TEMP_CAL:    temp_cal_reg    <= cfg_wdata[47:0];
                REG_PRESS_CAL_A: press_cal_a_reg <= cfg_wdata;
                REG_PRESS_CAL_B: press_cal_b_reg <= cfg_wdata;
                REG_PRESS_CAL_C: press_cal_c_reg <= cfg_wdata[15:0];
                REG_HUM_CAL_A:   hum_cal_a_reg   <= cfg_wdata[39:0];
                REG_HUM_CAL_B:   hum_cal_b_reg   <= cfg_wdata[31:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cal.t1 = temp_cal_reg[15:0];
        cal.t2 = temp_cal_reg[31:16];
        cal.t3 = temp_cal_reg[47:32];
        cal.p1 = press_cal_a_reg[15:0];
        cal.p2 = press_cal_a_reg[31:16];
        cal.p3 = press_cal_a_reg[47:32];
        cal.p4 = press_cal_a_reg[63:48];
        cal.p5 = press_cal_b_reg[15:0];
        cal.p6 = press_cal_b_reg[31:16];
        cal.p7 = press_cal_b_reg[47:32];
        cal.p8 = press_cal_b_reg[63:48];
        cal.p9 = press_cal_c_reg;
        cal.h1 = hum_cal_a_reg[7:0];
        cal.h2 = hum_cal_a_reg[23:8];
        cal.h3 = hum_cal_a_reg[31:24];
        cal.h6 = hum_cal_a_reg[39:32];
        cal.h4 = hum_cal_b_reg[15:0];
        cal.h5 = hum_cal_b_reg[31:16];
    end

    tph_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    tph_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wr_item   (push_item),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_valid),
        .rd_item   (pop_item)
    );

    tph_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (pop_item),
        .q_pop    (q_pop),
        .cal      (cal),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ----- sv/tph_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "temp_press_hum_compensation_assert.svh"

module tph_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [87:0] m_tdata
);

    `TPH_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
    `TPH_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata))
    `TPH_ASSERT_NOW(a_invalid_zero, m_tvalid && !m_tdata[81], m_tdata[80:0] == 81'd0)
    `TPH_ASSERT_NOW(a_hum_range, m_tvalid, m_tdata[80:64] <= 17'd102400)

endmodule

bind temp_press_hum_compensation tph_checker u_tph_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
